@@ rtl/core/vlch_pkg.sv @@
// Package with shared constants, types and opcodes of the label histogram.
package vlch_pkg;

   // The label fields are four bits wide, so the label count is fixed here.
   localparam int LabelCount           = 16;
   localparam int IntensityBitsDefault = 16;
   localparam int CountBitsDefault     = 32;

   localparam int OP_BITS    = 2;
   localparam int INT_W      = 16;
   localparam int LABEL_W    = 4;
   localparam int COST_W     = 17;
   localparam int FRAC_BITS  = 16;

   typedef enum logic [OP_BITS-1:0] {
      OP_LEARN = 2'd0,
      OP_UNARY = 2'd1,
      OP_PAIR  = 2'd2,
      OP_NONE  = 2'd3
   } op_type;

   // One queued transaction between the front and the back.
   typedef struct packed {
      op_type                  op;
      logic [INT_W-1:0]        intensity;
      logic [LABEL_W-1:0]      label;
      logic [LABEL_W-1:0]      second_label;
      logic [6*LABEL_W-1:0]    nbs;
   } cmd_type;

endpackage

@@ rtl/core/voxel_label_cooccurrence_histogram.sv @@
// Top level of the joint intensity and label histogram with cost queries.
//
//   channel | direction | handshake             | payload
//   req_    | in        | req_valid / req_ready | op, intensity, labels, neighbors
//   rsp_    | out       | rsp_valid / rsp_ready | cost (Q1.16), clamped
//
// A learn transaction holds the back end for a take step, a step that updates the label and
// intensity counters, and a read step plus a write step for each of the six pair counters.
// A query holds it through a take, a read of the counters, the 16-bit serial divider and an
// offer of the result; a zero divisor or a ratio of one or more skips the divider.
// After reset a clearing pass sweeps 2^(INTENSITY_BITS+4) addresses of the counter memories; the
// front queue keeps accepting up to four transactions during the pass or while rsp_ready is low.
module voxel_label_cooccurrence_histogram
   import vlch_pkg::*;
#(
   parameter int INTENSITY_BITS = IntensityBitsDefault,
   parameter int COUNT_BITS     = CountBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               req_valid,
   output logic               req_ready,
   input  logic [1:0]         req_op,
   input  logic signed [15:0] req_intensity,
   input  logic [3:0]         req_label,
   input  logic [3:0]         req_second_label,
   input  logic [3:0]         req_nb_xm,
   input  logic [3:0]         req_nb_ym,
   input  logic [3:0]         req_nb_zm,
   input  logic [3:0]         req_nb_xp,
   input  logic [3:0]         req_nb_yp,
   input  logic [3:0]         req_nb_zp,
   output logic               rsp_valid,
   input  logic               rsp_ready,
   output logic [16:0]        rsp_cost,
   output logic               rsp_clamped
);
   cmd_type in_cmd, q_cmd;
   logic    q_valid, q_ready, clearing;

   // Lower neighbors come first: they are counted as the first label.
   always_comb begin
      in_cmd.op           = op_type'(req_op);
      in_cmd.intensity    = req_intensity;
      in_cmd.label        = req_label;
      in_cmd.second_label = req_second_label;
      in_cmd.nbs          = {req_nb_zp, req_nb_yp, req_nb_xp,
                             req_nb_zm, req_nb_ym, req_nb_xm};
   end

   vlch_front u_front (
      .clock    (clock),
      .reset    (reset),
      .in_valid (req_valid),
      .in_ready (req_ready),
      .in_cmd   (in_cmd),
      .q_valid  (q_valid),
      .q_ready  (q_ready),
      .q_cmd    (q_cmd)
   );

   vlch_back #(
      .IntensityBits (INTENSITY_BITS),
      .CountBits     (COUNT_BITS)
   ) u_back (
      .clock       (clock),
      .reset       (reset),
      .q_valid     (q_valid),
      .q_ready     (q_ready),
      .q_cmd       (q_cmd),
      .out_valid   (rsp_valid),
      .out_ready   (rsp_ready),
      .out_cost    (rsp_cost),
      .out_clamped (rsp_clamped),
      .clearing    (clearing)
   );

   // A clamped answer always carries a zero cost.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_clamped |-> rsp_cost == '0)
      else $error("clamped result with nonzero cost");

   // No result is offered while the memories are being cleared.
   assert property (@(posedge clock) disable iff (reset)
      clearing |-> !rsp_valid)
      else $error("result during clearing pass");

   // Cost never exceeds one.
   assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> rsp_cost <= 17'h10000)
      else $error("cost above one");
endmodule

@@ rtl/core/vlch_front.sv @@
// Front end: accepts transactions, drops unused opcodes, queues the rest.
module vlch_front
   import vlch_pkg::*;
(
   input  logic    clock,
   input  logic    reset,
   input  logic    in_valid,
   output logic    in_ready,
   input  cmd_type in_cmd,
   output logic    q_valid,
   input  logic    q_ready,
   output cmd_type q_cmd
);
   localparam int DEPTH = 4;
   localparam int AW    = 2;

   cmd_type         buf_ff [DEPTH];
   logic [AW-1:0]   wr_ff, wr_in, rd_ff, rd_in;
   logic [AW:0]     cnt_ff, cnt_in;
   logic            push, pop;

   assign in_ready = (cnt_ff != (AW+1)'(DEPTH));
   assign push     = in_valid && in_ready && (in_cmd.op != OP_NONE);
   assign q_valid  = (cnt_ff != '0);
   assign pop      = q_valid && q_ready;
   assign q_cmd    = buf_ff[rd_ff];

   always_comb begin
      wr_in  = push ? wr_ff + 1'b1 : wr_ff;
      rd_in  = pop  ? rd_ff + 1'b1 : rd_ff;
      cnt_in = cnt_ff + (AW+1)'(push) - (AW+1)'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff  <= '0;
         rd_ff  <= '0;
         cnt_ff <= '0;
      end else begin
         wr_ff  <= wr_in;
         rd_ff  <= rd_in;
         cnt_ff <= cnt_in;
      end
      if (push) buf_ff[wr_ff] <= in_cmd;
   end
endmodule

@@ rtl/core/vlch_divider.sv @@
// Restoring divider giving 16 fraction bits of n/d for n < d, one bit a cycle.
module vlch_divider
   import vlch_pkg::*;
#(
   parameter int CountBits = CountBitsDefault
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 start,
   input  logic [CountBits-1:0] num,
   input  logic [CountBits-1:0] den,
   output logic                 busy,
   output logic                 done,
   output logic [FRAC_BITS-1:0] quot
);
   logic [CountBits:0]   rem_ff, rem_in;
   logic [CountBits-1:0] den_ff;
   logic [FRAC_BITS-1:0] q_ff, q_in;
   logic [4:0]           cnt_ff, cnt_in;
   logic                 busy_ff, busy_in, done_ff, done_in;
   logic [CountBits:0]   shl, dx;

   assign shl = {rem_ff[CountBits-1:0], 1'b0};
   assign dx  = {1'b0, den_ff};

   always_comb begin
      rem_in  = rem_ff;
      q_in    = q_ff;
      cnt_in  = cnt_ff;
      busy_in = busy_ff;
      done_in = 1'b0;
      if (start) begin
         rem_in  = {1'b0, num};
         q_in    = '0;
         cnt_in  = '0;
         busy_in = 1'b1;
      end else if (busy_ff) begin
         if (shl >= dx) begin
            rem_in = shl - dx;
            q_in   = {q_ff[FRAC_BITS-2:0], 1'b1};
         end else begin
            rem_in = shl;
            q_in   = {q_ff[FRAC_BITS-2:0], 1'b0};
         end
         cnt_in = cnt_ff + 5'd1;
         if (cnt_ff == 5'(FRAC_BITS-1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
      end
      rem_ff <= rem_in;
      q_ff   <= q_in;
      cnt_ff <= cnt_in;
      if (start) den_ff <= den;
   end

   assign busy = busy_ff;
   assign done = done_ff;
   assign quot = q_ff;
endmodule

@@ rtl/core/vlch_back.sv @@
// Back end: counter memories, clearing pass, learn sequencer and query cost.
module vlch_back
   import vlch_pkg::*;
#(
   parameter int IntensityBits = IntensityBitsDefault,
   parameter int CountBits     = CountBitsDefault
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               q_valid,
   output logic               q_ready,
   input  cmd_type            q_cmd,
   output logic               out_valid,
   input  logic               out_ready,
   output logic [COST_W-1:0]  out_cost,
   output logic               out_clamped,
   output logic               clearing
);
   localparam int LW     = (LabelCount > 1) ? $clog2(LabelCount) : 1;
   localparam int IW     = IntensityBits + LW;
   localparam int PW     = 2 * LW;
   localparam int IDEPTH = 1 << IW;
   localparam int PDEPTH = 1 << PW;
   localparam logic [CountBits-1:0] CMAX = '1;

   typedef enum logic [7:0] {
      S_CLEAR = 8'b00000001,
      S_IDLE  = 8'b00000010,
      S_LREAD = 8'b00000100,
      S_LPRD  = 8'b00001000,
      S_LPWR  = 8'b00010000,
      S_QREAD = 8'b00100000,
      S_QDIV  = 8'b01000000,
      S_OUT   = 8'b10000000
   } state_type;

   state_type state_ff, state_in;

   // Memories: label counts and pair counts are small, intensity-label large.
   logic [CountBits-1:0] lab_mem  [LabelCount];
   logic [CountBits-1:0] pair_mem [PDEPTH];
   logic [CountBits-1:0] int_mem  [IDEPTH];

   logic [IW-1:0] clr_ff, clr_in;
   cmd_type       cmd_ff;
   logic [2:0]    pidx_ff, pidx_in;
   logic          ok_lab, ok_lab2;

   logic [LW-1:0]        lab, lab2;
   logic [IntensityBits-1:0] row;
   logic [IW-1:0]        iaddr;
   logic [PW-1:0]        paddr;
   logic [CountBits-1:0] lab_rd_ff, int_rd_ff, pair_rd_ff, pair_cur_ff;
   logic [LABEL_W-1:0]   nb;
   logic [LW-1:0]        pa, pb;
   logic                 pok;
   logic                 pair_wr;
   logic [CountBits-1:0] pair_wd;
   logic [CountBits-1:0] num_ff, den_ff;
   logic [COST_W-1:0]    cost_ff, cost_in;
   logic                 clamp_ff, clamp_in;
   logic                 div_start, div_busy, div_done;
   logic [FRAC_BITS-1:0] div_q;
   logic                 rd_pair_hit_ff;
   logic                 spec;
   logic [COST_W-1:0]    spec_cost;
   logic                 spec_clamp;
   logic [CountBits-1:0] n_sel, d_sel;

   assign lab  = cmd_ff.label[LW-1:0];
   assign lab2 = cmd_ff.second_label[LW-1:0];
   assign row  = IntensityBits'(cmd_ff.intensity);
   assign ok_lab  = ({4'b0, cmd_ff.label}        < 8'(LabelCount));
   assign ok_lab2 = ({4'b0, cmd_ff.second_label} < 8'(LabelCount));
   assign iaddr  = {row, lab};

   // Neighbor selection for the pair step: three lower, three upper.
   always_comb begin
      case (pidx_ff)
         3'd0:    nb = cmd_ff.nbs[LABEL_W*0 +: LABEL_W];
         3'd1:    nb = cmd_ff.nbs[LABEL_W*1 +: LABEL_W];
         3'd2:    nb = cmd_ff.nbs[LABEL_W*2 +: LABEL_W];
         3'd3:    nb = cmd_ff.nbs[LABEL_W*3 +: LABEL_W];
         3'd4:    nb = cmd_ff.nbs[LABEL_W*4 +: LABEL_W];
         default: nb = cmd_ff.nbs[LABEL_W*5 +: LABEL_W];
      endcase
      pok = ok_lab && ({4'b0, nb} < 8'(LabelCount));
      if (pidx_ff < 3'd3) begin
         pa = nb[LW-1:0];
         pb = lab;
      end else begin
         pa = lab;
         pb = nb[LW-1:0];
      end
      paddr = {pa, pb};
   end

   // Each pair step reads the entry in S_LPRD and writes it back in S_LPWR.
   assign pair_wr = (state_ff == S_LPWR) && pok;
   assign pair_wd = (pair_cur_ff == CMAX) ? CMAX : pair_cur_ff + 1'b1;

   assign q_ready   = (state_ff == S_IDLE);
   assign div_start = (state_ff == S_QDIV) && !div_busy && !div_done
                      && !rd_pair_hit_ff;

   vlch_divider #(.CountBits(CountBits)) u_div (
      .clock (clock),
      .reset (reset),
      .start (div_start),
      .num   (num_ff),
      .den   (den_ff),
      .busy  (div_busy),
      .done  (div_done),
      .quot  (div_q)
   );

   // Special cases decided directly: zero divisor, ratio of one, above one.
   always_comb begin
      d_sel = ok_lab ? lab_rd_ff : '0;
      if (!ok_lab) n_sel = '0;
      else if (cmd_ff.op == OP_UNARY) n_sel = int_rd_ff;
      else if (ok_lab2) n_sel = pair_rd_ff;
      else n_sel = '0;
      spec       = 1'b1;
      spec_clamp = 1'b0;
      spec_cost  = '0;
      if (d_sel == '0) spec_cost = COST_W'(1 << FRAC_BITS);
      else if (n_sel > d_sel) spec_clamp = 1'b1;
      else if (n_sel == d_sel) spec_cost = '0;
      else spec = 1'b0;
   end

   always_comb begin
      state_in = state_ff;
      clr_in   = clr_ff;
      pidx_in  = pidx_ff;
      cost_in  = cost_ff;
      clamp_in = clamp_ff;
      case (state_ff)
         S_CLEAR: begin
            clr_in = clr_ff + 1'b1;
            if (clr_ff == IW'(IDEPTH-1)) state_in = S_IDLE;
         end
         S_IDLE: begin
            if (q_valid) begin
               state_in = (q_cmd.op == OP_LEARN) ? S_LREAD : S_QREAD;
            end
         end
         S_LREAD: begin
            pidx_in  = '0;
            state_in = S_LPRD;
         end
         S_LPRD: state_in = S_LPWR;
         S_LPWR: begin
            pidx_in  = pidx_ff + 3'd1;
            state_in = (pidx_ff == 3'd5) ? S_IDLE : S_LPRD;
         end
         S_QREAD: begin
            if (spec) begin
               cost_in  = spec_cost;
               clamp_in = spec_clamp;
            end
            state_in = S_QDIV;
         end
         S_QDIV: begin
            if (rd_pair_hit_ff) begin
               state_in = S_OUT;
            end else if (div_done) begin
               cost_in  = COST_W'(1 << FRAC_BITS) - COST_W'(div_q);
               clamp_in = 1'b0;
               state_in = S_OUT;
            end
         end
         S_OUT: if (out_ready) state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_CLEAR;
         clr_ff   <= '0;
      end else begin
         state_ff <= state_in;
         clr_ff   <= clr_in;
      end
      pidx_ff  <= pidx_in;
      cost_ff  <= cost_in;
      clamp_ff <= clamp_in;
      if (state_ff == S_IDLE && q_valid) cmd_ff <= q_cmd;
      if (state_ff == S_QREAD) begin
         num_ff         <= n_sel;
         den_ff         <= d_sel;
         rd_pair_hit_ff <= spec;
      end
   end

   // Registered reads of the stores (query and counter reads taken in S_IDLE).
   always_ff @(posedge clock) begin
      lab_rd_ff   <= lab_mem[q_cmd.label[LW-1:0]];
      pair_rd_ff  <= pair_mem[{q_cmd.label[LW-1:0], q_cmd.second_label[LW-1:0]}];
      int_rd_ff   <= int_mem[{IntensityBits'(q_cmd.intensity), q_cmd.label[LW-1:0]}];
      pair_cur_ff <= pair_mem[paddr];
   end

   // Writes: clearing pass, then learn increments.
   always_ff @(posedge clock) begin
      if (state_ff == S_CLEAR) begin
         int_mem[clr_ff] <= '0;
         if (clr_ff < IW'(PDEPTH)) pair_mem[clr_ff[PW-1:0]] <= '0;
         if (clr_ff < IW'(LabelCount)) lab_mem[clr_ff[LW-1:0]] <= '0;
      end else if (state_ff == S_LREAD && ok_lab) begin
         lab_mem[lab]   <= (lab_rd_ff == CMAX) ? CMAX : lab_rd_ff + 1'b1;
         int_mem[iaddr] <= (int_rd_ff == CMAX) ? CMAX : int_rd_ff + 1'b1;
      end
      if (pair_wr) pair_mem[paddr] <= pair_wd;
   end

   assign out_valid   = (state_ff == S_OUT);
   assign out_cost    = cost_ff;
   assign out_clamped = clamp_ff;
   assign clearing    = (state_ff == S_CLEAR);
endmodule

@@ verif/tb_voxel_label_cooccurrence_histogram.sv @@
// Testbench of the label histogram: directed table, then random traffic checked by a predictor.
module tb_voxel_label_cooccurrence_histogram;
   import vlch_pkg::*;

   // The block clears 2^16 * 16 counter entries after reset. The limit covers that pass
   // several times over, plus every transaction at its slowest.
   localparam int LimitCycles = 6_000_000;
   localparam int RandomItems = 1100;
   localparam int DirRows     = 14;

   logic        clock;
   logic        reset;
   logic        req_valid;
   logic        req_ready;
   logic [1:0]  req_op;
   logic signed [15:0] req_intensity;
   logic [3:0]  req_label, req_second_label;
   logic [3:0]  req_nb_xm, req_nb_ym, req_nb_zm, req_nb_xp, req_nb_yp, req_nb_zp;
   logic        rsp_valid;
   logic        rsp_ready;
   logic [16:0] rsp_cost;
   logic        rsp_clamped;

   voxel_label_cooccurrence_histogram uut (.*);

   always #2 clock = ~clock;

   // One expected answer of a query.
   typedef struct {
      bit [16:0] cost;
      bit        clamped;
   } cost_answer;

   // One row of the directed table. The nibbles of nbs are xm, ym, zm, xp, yp, zp from the
   // top. Where known is set, the answer is typed in and replaces the predicted one.
   typedef struct {
      op_type     op;
      bit [15:0]  inten;
      bit [3:0]   lab;
      bit [3:0]   lab2;
      bit [23:0]  nbs;
      bit         known;
      bit [16:0]  cost;
      bit         clamped;
   } dir_row;

   // Our own copy of the histogram.
   bit [31:0] label_tally [16];
   bit [31:0] pair_tally [256];
   bit [31:0] joint_tally [int];

   cost_answer pending_costs[$];
   int         errors;
   int         answers_seen;
   bit         sender_done;
   dir_row     dir_tab [DirRows];

   // Saturating increment of a pair counter.
   task automatic bump_pair(bit [3:0] a, bit [3:0] b);
      if (pair_tally[{a, b}] != 32'hFFFF_FFFF) pair_tally[{a, b}]++;
   endtask

   // Updates the copy for one accepted transaction and computes its answer, if any.
   task automatic predict_cost(input op_type op, input bit [15:0] inten, input bit [3:0] lab,
                               input bit [3:0] lab2, input bit [23:0] nbs,
                               output bit has_answer, output cost_answer ans);
      int        key;
      bit [63:0] num, den;
      key = {inten, lab};
      has_answer = 0;
      ans = '{cost: 17'd0, clamped: 1'b0};
      if (op == OP_LEARN) begin
         if (label_tally[lab] != 32'hFFFF_FFFF) label_tally[lab]++;
         if (!joint_tally.exists(key)) joint_tally[key] = 0;
         if (joint_tally[key] != 32'hFFFF_FFFF) joint_tally[key]++;
         // Lower neighbors come first in the pair, upper neighbors second.
         bump_pair(nbs[23:20], lab);
         bump_pair(nbs[19:16], lab);
         bump_pair(nbs[15:12], lab);
         bump_pair(lab, nbs[11:8]);
         bump_pair(lab, nbs[7:4]);
         bump_pair(lab, nbs[3:0]);
      end else if (op != OP_NONE) begin
         has_answer = 1;
         den = label_tally[lab];
         if (op == OP_UNARY) num = joint_tally.exists(key) ? joint_tally[key] : 0;
         else num = pair_tally[{lab, lab2}];
         if (den == 0) ans.cost = 17'h10000;
         else if (num > den) ans.clamped = 1;
         else if (num < den) ans.cost = 17'h10000 - 17'((num << 16) / den);
      end
   endtask

   // Drives one transaction, called at a falling edge, and returns at a falling edge.
   task automatic send_item(op_type op, bit [15:0] inten, bit [3:0] lab, bit [3:0] lab2,
                            bit [23:0] nbs, bit known, cost_answer typed, int gap);
      bit         has_answer;
      cost_answer ans;
      if (gap > 0) begin
         req_valid <= 0;
         repeat (gap) @(negedge clock);
      end
      req_op <= op;
      req_intensity <= inten;
      req_label <= lab;
      req_second_label <= lab2;
      {req_nb_xm, req_nb_ym, req_nb_zm, req_nb_xp, req_nb_yp, req_nb_zp} <= nbs;
      req_valid <= 1;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      predict_cost(op, inten, lab, lab2, nbs, has_answer, ans);
      if (has_answer) pending_costs.insert(pending_costs.size(), known ? typed : ans);
      @(negedge clock);
   endtask

   // Mostly a few labels so that counters grow and ratios get interesting.
   function automatic bit [3:0] pick_label();
      return ($urandom_range(0, 9) < 7) ? 4'($urandom_range(0, 3)) : 4'($urandom);
   endfunction

   initial begin
      clock = 0;
      reset = 1;
      req_valid = 0;
      req_op = OP_NONE;
      req_intensity = 0;
      req_label = 0;
      req_second_label = 0;
      {req_nb_xm, req_nb_ym, req_nb_zm, req_nb_xp, req_nb_yp, req_nb_zp} = '0;
      errors = 0;
      answers_seen = 0;
      sender_done = 0;
   end

   // Directed table. Queries on an empty histogram answer one, a unary query right after a
   // single learn answers zero, and a pair seen three times for a label counted once clamps.
   initial begin
      dir_tab = '{
         '{OP_UNARY, 16'h0000, 4'd0,  4'd0,  24'h000000, 1, 17'h10000, 0},
         '{OP_PAIR,  16'h0000, 4'd15, 4'd15, 24'h000000, 1, 17'h10000, 0},
         '{OP_NONE,  16'hFFFF, 4'd15, 4'd15, 24'hFFFFFF, 0, 17'h0,     0},
         '{OP_LEARN, 16'h8000, 4'd15, 4'd0,  24'h0F0F0F, 0, 17'h0,     0},
         '{OP_UNARY, 16'h8000, 4'd15, 4'd0,  24'h000000, 1, 17'h0,     0},
         '{OP_LEARN, 16'h7FFF, 4'd0,  4'd15, 24'hFFFFFF, 0, 17'h0,     0},
         '{OP_LEARN, 16'h7FFF, 4'd0,  4'd0,  24'h000000, 0, 17'h0,     0},
         '{OP_UNARY, 16'h7FFF, 4'd0,  4'd0,  24'h000000, 1, 17'h0,     0},
         '{OP_LEARN, 16'h0001, 4'd5,  4'd0,  24'h000000, 0, 17'h0,     0},
         '{OP_LEARN, 16'hFFFF, 4'd3,  4'd0,  24'h555123, 0, 17'h0,     0},
         '{OP_PAIR,  16'h0000, 4'd5,  4'd3,  24'h000000, 1, 17'h0,     1},
         '{OP_PAIR,  16'h0000, 4'd0,  4'd15, 24'h000000, 0, 17'h0,     0},
         '{OP_UNARY, 16'h1234, 4'd0,  4'd0,  24'h000000, 0, 17'h0,     0},
         '{OP_PAIR,  16'h0000, 4'd3,  4'd1,  24'h000000, 0, 17'h0,     0}
      };
   end

   // Sender: directed rows, then random traffic with one pause that lets the block drain.
   initial begin
      op_type     op;
      bit [15:0]  inten;
      bit [23:0]  nbs;
      int         roll;
      cost_answer none;
      none = '{cost: 17'd0, clamped: 1'b0};
      repeat (9) @(posedge clock);
      @(negedge clock);
      reset <= 0;
      foreach (dir_tab[i])
         send_item(dir_tab[i].op, dir_tab[i].inten, dir_tab[i].lab, dir_tab[i].lab2,
                   dir_tab[i].nbs, dir_tab[i].known,
                   '{cost: dir_tab[i].cost, clamped: dir_tab[i].clamped},
                   $urandom_range(0, 8));
      for (int n = 0; n < RandomItems; n++) begin
         roll = $urandom_range(0, 99);
         op = op_type'((roll < 50) ? OP_LEARN : (roll < 72) ? OP_UNARY :
                       (roll < 95) ? OP_PAIR : OP_NONE);
         inten = ($urandom_range(0, 9) < 7) ? 16'($signed($urandom_range(0, 7)) - 4)
                                            : 16'($urandom);
         nbs = {pick_label(), pick_label(), pick_label(), pick_label(), pick_label(),
                pick_label()};
         if ($urandom_range(0, 19) == 0) nbs = 24'($urandom);
         if (n == RandomItems / 2) begin
            // Hold off until every outstanding answer has come back.
            req_valid <= 0;
            while (pending_costs.size() != 0) @(negedge clock);
         end
         // Every fourth stretch of fifty items runs back to back.
         send_item(op, inten, pick_label(), pick_label(), nbs, 0, none,
                   ((n / 50) % 4 == 3) ? 0 : $urandom_range(0, 8));
      end
      req_valid <= 0;
      sender_done = 1;
   end

   // Receiver: random stalls per answer, and once a long stall that fills the block.
   initial begin
      int wait_cycles;
      rsp_ready = 0;
      @(negedge clock);
      forever begin
         wait_cycles = $urandom_range(0, 8);
         if (answers_seen == 60) wait_cycles = 400;
         else if ((answers_seen / 40) % 3 == 2) wait_cycles = 0;
         if (wait_cycles > 0) begin
            rsp_ready <= 0;
            repeat (wait_cycles) @(negedge clock);
         end
         rsp_ready <= 1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         @(negedge clock);
      end
   end

   // Each accepted answer is checked against the oldest expected one.
   always @(posedge clock) begin
      cost_answer want;
      if (!reset && rsp_valid && rsp_ready) begin
         answers_seen <= answers_seen + 1;
         if (pending_costs.size() == 0) begin
            $display("%0t: unexpected answer cost=%0d clamped=%0d", $time, rsp_cost,
                     rsp_clamped);
            errors++;
         end else begin
            want = pending_costs.pop_front();
            if (rsp_cost !== want.cost) begin
               $display("%0t: cost expected %0d actual %0d", $time, want.cost, rsp_cost);
               errors++;
            end
            if (rsp_clamped !== want.clamped) begin
               $display("%0t: clamped expected %0d actual %0d", $time, want.clamped,
                        rsp_clamped);
               errors++;
            end
         end
      end
   end

   // End of the run: drain, wait on so that any answer beyond the expected ones shows, then report.
   initial begin
      @(posedge sender_done);
      while (pending_costs.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (errors == 0 && pending_costs.size() == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

   // Watchdog.
   initial begin
      #(4 * LimitCycles);
      $display("status: fail");
      $finish;
   end

endmodule
